// File: hdl/lcpe_pkg.sv
// Shared types and constants of the LED chain pulse encoder.
`timescale 1ns / 1ps
package lcpe_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  localparam logic [7:0] REG_HIGH_DUTY     = 8'd0;
  localparam logic [7:0] REG_LOW_DUTY      = 8'd1;
  localparam logic [7:0] REG_RESET_SLOTS   = 8'd2;
  localparam logic [7:0] REG_PIXELS_IN_USE = 8'd3;

  localparam logic [7:0] HIGH_DUTY_RST     = 8'd13;
  localparam logic [7:0] LOW_DUTY_RST      = 8'd6;
  localparam logic [7:0] RESET_SLOTS_RST   = 8'd40;
  localparam logic [3:0] PIXELS_IN_USE_RST = 4'd7;

  localparam int unsigned SlotsPerPixel = 24;
  localparam int unsigned PixelBits     = 24;

  typedef struct packed {
    op_e         op;
    logic        bank;
    logic        rd_valid;
    logic [1:0]  byte_sel;
    logic [2:0]  bit_sel;
    logic        is_data;
    logic        last;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [23:0] wdata;
  } entry_t;

endpackage

// File: hdl/rgb_led_chain_pulse_encoder_unit.sv
// Top level of the LED chain pulse encoder: front end, queue and back end.
//
//   port group  | dir | beat contents
//   s_axis      | in  | tdata: pixel_index, red, green, blue; tuser: action
//   m_axis      | out | tdata: duty; tlast: last slot of the frame
//   cfg         | in  | cfg_index_i selects register, cfg_data_i holds value
//
// One input beat is taken every cycle while the four-entry queue has room.
// A tick passes from its beat through the queue, the bank read and then the output register to m_axis.
// Output back-pressure stalls the back end only; the front keeps filling the queue.
// Reset clears control state and the per-pixel valid bits of both banks; no clearing pass.
`timescale 1ns / 1ps
module rgb_led_chain_pulse_encoder_unit #(
  parameter int unsigned MAX_PIXELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_index, red, green, blue
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // duty
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned QW = AW + $bits(lcpe_pkg::entry_t);

  logic             accept, push, pop, full, empty;
  lcpe_pkg::entry_t f_entry, b_entry;
  logic [AW-1:0]    f_addr, b_addr;
  logic [QW-1:0]    q_rdata;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  lcpe_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_accept_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .action_i      (lcpe_pkg::action_e'(s_axis_tuser)),
    .pixel_index_i (s_axis_tdata[7:0]),
    .red_i         (s_axis_tdata[15:8]),
    .green_i       (s_axis_tdata[23:16]),
    .blue_i        (s_axis_tdata[31:24]),
    .push_o        (push),
    .entry_o       (f_entry),
    .addr_o        (f_addr)
  );

  lcpe_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_addr, f_entry}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign b_addr  = q_rdata[QW-1 -: AW];
  assign b_entry = lcpe_pkg::entry_t'(q_rdata[$bits(lcpe_pkg::entry_t)-1:0]);

  lcpe_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (b_entry),
    .addr_i      (b_addr),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .duty_o      (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

// File: hdl/lcpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lcpe_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lcpe_queue.sv
// Four-entry first-in first-out queue between front and back.
`timescale 1ns / 1ps
module lcpe_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [4];
  logic [1:0]       wr_q, wr_d;
  logic [1:0]       rd_q, rd_d;
  logic [2:0]       cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 2'd1;
    end
    if (pop_i) begin
      rd_d = rd_q + 2'd1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 3'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[rd_q];
  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);

endmodule

// File: hdl/lcpe_front.sv
// Front end: configuration, item classification, frame sequencing and bank bookkeeping.
`timescale 1ns / 1ps
module lcpe_front #(
  parameter int unsigned MAX_PIXELS = 8,
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1),
  localparam int unsigned SW = $clog2(MAX_PIXELS * 24 + 256)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_accept_i,
  input  logic [7:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  accept_i,
  input  lcpe_pkg::action_e     action_i,
  input  logic [7:0]            pixel_index_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  output logic                  push_o,
  output lcpe_pkg::entry_t      entry_o,
  output logic [AW-1:0]         addr_o
);

  logic [7:0]            hi_q, lo_q, rs_q;
  logic [3:0]            piu_q;
  logic                  run_q;
  logic [SW-1:0]         slot_q, data_q, total_q;
  logic [7:0]            lat_hi_q, lat_lo_q;
  logic [2:0]            bit_q;
  logic [1:0]            byte_q;
  logic [AW-1:0]         pix_q;
  logic [MAX_PIXELS-1:0] cur_q, fr_q, vld0_q, vld1_q;

  logic [CW-1:0]         count;
  logic [SW-1:0]         data_slots, total_slots;
  logic                  idx_ok, last;
  logic [AW-1:0]         waddr;
  logic                  do_write, do_start, do_tick;

  always_comb begin
    if (32'(piu_q) > MAX_PIXELS) begin
      count = CW'(MAX_PIXELS);
    end else begin
      count = CW'(piu_q);
    end
  end

  assign data_slots  = SW'(count) * SW'(lcpe_pkg::SlotsPerPixel);
  assign total_slots = data_slots + SW'(rs_q);
  assign idx_ok      = 32'(pixel_index_i) < 32'(count);
  assign waddr       = AW'(pixel_index_i);
  assign last        = (slot_q + SW'(1)) >= total_q;

  always_comb begin
    do_write = 1'b0;
    do_start = 1'b0;
    do_tick  = 1'b0;
    case (action_i)
      lcpe_pkg::ACT_WRITE: begin
        do_write = accept_i && idx_ok;
      end
      lcpe_pkg::ACT_START: begin
        do_start = accept_i && !run_q && (total_slots != '0);
      end
      lcpe_pkg::ACT_TICK: begin
        do_tick = accept_i && run_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    entry_o          = '0;
    entry_o.wdata    = {blue_i, red_i, green_i};
    entry_o.hi       = lat_hi_q;
    entry_o.lo       = lat_lo_q;
    entry_o.is_data  = slot_q < data_q;
    entry_o.last     = last;
    entry_o.bit_sel  = bit_q;
    entry_o.byte_sel = byte_q;
    if (do_tick) begin
      entry_o.op       = lcpe_pkg::OP_TICK;
      entry_o.bank     = fr_q[pix_q];
      entry_o.rd_valid = fr_q[pix_q] ? vld1_q[pix_q] : vld0_q[pix_q];
      addr_o           = pix_q;
    end else begin
      entry_o.op       = lcpe_pkg::OP_WRITE;
      entry_o.bank     = ~fr_q[waddr];
      entry_o.rd_valid = 1'b0;
      addr_o           = waddr;
    end
  end

  assign push_o = do_write || do_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q  <= lcpe_pkg::HIGH_DUTY_RST;
      lo_q  <= lcpe_pkg::LOW_DUTY_RST;
      rs_q  <= lcpe_pkg::RESET_SLOTS_RST;
      piu_q <= lcpe_pkg::PIXELS_IN_USE_RST;
    end else if (cfg_accept_i) begin
      case (cfg_index_i)
        lcpe_pkg::REG_HIGH_DUTY:     hi_q  <= cfg_data_i;
        lcpe_pkg::REG_LOW_DUTY:      lo_q  <= cfg_data_i;
        lcpe_pkg::REG_RESET_SLOTS:   rs_q  <= cfg_data_i;
        lcpe_pkg::REG_PIXELS_IN_USE: piu_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      slot_q   <= '0;
      data_q   <= '0;
      total_q  <= '0;
      lat_hi_q <= 8'd0;
      lat_lo_q <= 8'd0;
      bit_q    <= 3'd0;
      byte_q   <= 2'd0;
      pix_q    <= '0;
      cur_q    <= '0;
      fr_q     <= '0;
      vld0_q   <= '0;
      vld1_q   <= '0;
    end else begin
      if (do_write) begin
        cur_q[waddr] <= ~fr_q[waddr];
        if (fr_q[waddr]) begin
          vld0_q[waddr] <= 1'b1;
        end else begin
          vld1_q[waddr] <= 1'b1;
        end
      end
      if (do_start) begin
        run_q    <= 1'b1;
        slot_q   <= '0;
        data_q   <= data_slots;
        total_q  <= total_slots;
        lat_hi_q <= hi_q;
        lat_lo_q <= lo_q;
        bit_q    <= 3'd0;
        byte_q   <= 2'd0;
        pix_q    <= '0;
        fr_q     <= cur_q;
      end
      if (do_tick) begin
        if (last) begin
          run_q  <= 1'b0;
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + SW'(1);
          if (bit_q == 3'd7) begin
            bit_q <= 3'd0;
            if (byte_q == 2'd2) begin
              byte_q <= 2'd0;
              pix_q  <= pix_q + AW'(1);
            end else begin
              byte_q <= byte_q + 2'd1;
            end
          end else begin
            bit_q <= bit_q + 3'd1;
          end
        end
      end
    end
  end

endmodule

// File: hdl/lcpe_back.sv
// Back end: pixel banks, bit selection and the output register.
`timescale 1ns / 1ps
module lcpe_back #(
  parameter int unsigned MAX_PIXELS = 8,
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  lcpe_pkg::entry_t entry_i,
  input  logic [AW-1:0]    addr_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       duty_o,
  output logic             last_o
);

  logic             s1_valid_q;
  lcpe_pkg::entry_t s1_q;
  logic             out_valid_q;
  logic [7:0]       duty_q;
  logic             last_q;

  logic             out_free, s1_free, tick_pop;
  logic             we0, we1;
  logic [lcpe_pkg::PixelBits-1:0] rdata0, rdata1, word;
  logic [7:0]       byte_v, duty_c;
  logic             bit_v;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign pop_o    = !empty_i && s1_free;
  assign tick_pop = pop_o && (entry_i.op == lcpe_pkg::OP_TICK);
  assign we0      = pop_o && (entry_i.op == lcpe_pkg::OP_WRITE) && !entry_i.bank;
  assign we1      = pop_o && (entry_i.op == lcpe_pkg::OP_WRITE) && entry_i.bank;

  lcpe_ram #(
    .WIDTH (lcpe_pkg::PixelBits),
    .DEPTH (MAX_PIXELS)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (addr_i),
    .wdata_i (entry_i.wdata),
    .re_i    (tick_pop),
    .raddr_i (addr_i),
    .rdata_o (rdata0)
  );

  lcpe_ram #(
    .WIDTH (lcpe_pkg::PixelBits),
    .DEPTH (MAX_PIXELS)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (addr_i),
    .wdata_i (entry_i.wdata),
    .re_i    (tick_pop),
    .raddr_i (addr_i),
    .rdata_o (rdata1)
  );

  assign word = s1_q.bank ? rdata1 : rdata0;

  always_comb begin
    case (s1_q.byte_sel)
      2'd0:    byte_v = word[7:0];
      2'd1:    byte_v = word[15:8];
      2'd2:    byte_v = word[23:16];
      default: byte_v = 8'd0;
    endcase
    bit_v = s1_q.rd_valid && byte_v[3'd7 - s1_q.bit_sel];
    if (!s1_q.is_data) begin
      duty_c = 8'd0;
    end else if (bit_v) begin
      duty_c = s1_q.hi;
    end else begin
      duty_c = s1_q.lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= tick_pop;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_pop) begin
      s1_q <= entry_i;
    end
    if (out_free && s1_valid_q) begin
      duty_q <= duty_c;
      last_q <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign last_o      = last_q;

endmodule
